// ===== hw/rtl/upd_pkg.sv =====
// ============================================================================
// upd_pkg
// Shared types, character constants and helper functions for the URL
// percent decoder.
// ============================================================================
package upd_pkg;

    // Characters with a special meaning in form-urlencoded text.
    localparam logic [7:0] C_PLUS    = 8'h2B;
    localparam logic [7:0] C_PERCENT = 8'h25;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_DIG_0   = 8'h30;
    localparam logic [7:0] C_DIG_9   = 8'h39;
    localparam logic [7:0] C_UP_A    = 8'h41;
    localparam logic [7:0] C_UP_F    = 8'h46;
    localparam logic [7:0] C_LO_A    = 8'h61;
    localparam logic [7:0] C_LO_F    = 8'h66;

    // Offset that maps the low nibble of a letter digit to its value.
    localparam logic [3:0] C_LETTER_OFS = 4'd9;

    // Command queue between the front and back parts.
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Maximum number of output bytes caused by one input byte.
    localparam int unsigned MAX_OUT = 3;

    // Escape progress of the front part.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // One classified input byte: up to three output bytes in order.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] data;
        logic [1:0]              cnt;
        logic                    last;
    } t_cmd;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic is_hex(input logic [7:0] b);
        is_hex = (b >= C_DIG_0 && b <= C_DIG_9) ||
                 (b >= C_UP_A && b <= C_UP_F) ||
                 (b >= C_LO_A && b <= C_LO_F);
    endfunction

    // Value of a hex digit; letters of either case share the low nibble.
    function automatic logic [3:0] hex_val(input logic [7:0] b);
        if (b >= C_DIG_0 && b <= C_DIG_9) begin
            hex_val = b[3:0];
        end else begin
            hex_val = b[3:0] + C_LETTER_OFS;
        end
    endfunction

endpackage

// ===== hw/rtl/upd_if.sv =====
// ============================================================================
// upd_if
// Valid/ready channel interfaces for the encoded input and decoded output.
// ============================================================================
interface upd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hw/rtl/upd_front.sv =====
// ============================================================================
// upd_front
// Accepts encoded bytes, tracks escape progress and turns each byte into a
// command of zero to three output bytes.
// ============================================================================
module upd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    upd_in_if.sink             i_in,
    input  upd_pkg::t_q_status i_q_status,
    output logic               o_push,
    output upd_pkg::t_cmd      o_cmd
);
    import upd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       accept;
    logic       b_hex;
    logic       starts_escape;
    logic       plain_emit;
    logic [7:0] plain_byte;
    t_cmd       cmd;

    // A transfer is taken whenever the queue has room for its command.
    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    // Classification of the byte as an ordinary character.
    assign b_hex         = is_hex(i_in.in_byte);
    assign starts_escape = (i_in.in_byte == C_PERCENT) && !i_in.in_last;
    assign plain_emit    = !starts_escape;
    assign plain_byte    = (i_in.in_byte == C_PLUS) ? C_SPACE : i_in.in_byte;

    // Next escape phase and held digit.
    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        case (r_phase)
            PH_PCT: begin
                if (b_hex && !i_in.in_last) begin
                    n_phase = PH_DIGIT;
                    n_held  = i_in.in_byte;
                end else begin
                    n_phase = starts_escape ? PH_PCT : PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (b_hex) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = starts_escape ? PH_PCT : PH_IDLE;
                end
            end
            default: begin
                n_phase = starts_escape ? PH_PCT : PH_IDLE;
            end
        endcase
    end

    // Output bytes caused by the current byte.
    always_comb begin
        cmd      = '0;
        cmd.last = i_in.in_last;
        case (r_phase)
            PH_PCT: begin
                if (!(b_hex && !i_in.in_last)) begin
                    cmd.data[0] = C_PERCENT;
                    cmd.data[1] = plain_byte;
                    cmd.cnt     = plain_emit ? 2'd2 : 2'd1;
                end
            end
            PH_DIGIT: begin
                if (b_hex) begin
                    cmd.data[0] = {hex_val(r_held), hex_val(i_in.in_byte)};
                    cmd.cnt     = 2'd1;
                end else begin
                    cmd.data[0] = C_PERCENT;
                    cmd.data[1] = r_held;
                    cmd.data[2] = plain_byte;
                    cmd.cnt     = plain_emit ? 2'd3 : 2'd2;
                end
            end
            default: begin
                cmd.data[0] = plain_byte;
                cmd.cnt     = plain_emit ? 2'd1 : 2'd0;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.cnt != 2'd0);

    // Escape phase register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    // Held first digit; only read while a digit is pending.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

// ===== hw/rtl/upd_queue.sv =====
// ============================================================================
// upd_queue
// Short first-in first-out queue of commands between front and back parts.
// ============================================================================
module upd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  upd_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output upd_pkg::t_cmd       o_head,
    output upd_pkg::t_q_status  o_status
);
    import upd_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/upd_back.sv =====
// ============================================================================
// upd_back
// Walks the bytes of the head command and feeds them, one per cycle while the
// receiver keeps taking them, into the output register.
// ============================================================================
module upd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  upd_pkg::t_cmd      i_head,
    input  upd_pkg::t_q_status i_q_status,
    output logic               o_pop,
    upd_out_if.source          o_out
);
    import upd_pkg::*;

    logic [1:0] r_sel, n_sel;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    // The output register takes a new byte when it is empty or being drained.
    assign load   = !i_q_status.empty && (!r_valid || o_out.ready);
    assign at_end = (r_sel == (i_head.cnt - 2'd1));
    assign o_pop  = load && at_end;
    assign n_sel  = at_end ? 2'd0 : (r_sel + 2'd1);

    // Byte of the head command at the current position.
    always_comb begin
        case (r_sel)
            2'd0:    sel_byte = i_head.data[0];
            2'd1:    sel_byte = i_head.data[1];
            2'd2:    sel_byte = i_head.data[2];
            default: sel_byte = i_head.data[0];
        endcase
    end

    // Position within the head command and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_sel   <= n_sel;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= i_head.last && at_end;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.out_last = r_last;

endmodule

// ===== hw/rtl/url_percent_decoder_unit.sv =====
// ============================================================================
// url_percent_decoder_unit
// Streaming decoder for form-urlencoded text, one byte per cycle while the command queue has room.
// ============================================================================
// Usage:
//   i_in carries raw characters with in_last on the final one of a string;
//   o_out carries decoded characters with out_last on the final one.
//   Both channels move a transfer when valid and ready are high together.
//   A '+' becomes a space, '%' with two hex digits becomes one byte, and a
//   broken escape is flushed literally before the breaking byte is decoded.
//   Path: the first output byte of an input passes the command queue and
//   then the output register. Throughput: one input byte per cycle while each
//   input yields at most one output byte and o_out.ready stays high; an input
//   with two or three bytes holds the queue head until all are loaded. The
//   front part keeps taking input until the four-entry command queue is full.
//   When the receiver holds o_out.ready low the output byte holds, the queue
//   fills and i_in.ready drops; no byte is lost.
//   Reset (i_rst_n low at a clock edge) clears the escape state, empties the
//   queue and drops o_out.valid.
// ============================================================================
module url_percent_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    upd_in_if.sink     i_in,
    upd_out_if.source  o_out
);
    import upd_pkg::*;

    t_cmd      front_cmd;
    t_cmd      head_cmd;
    t_q_status q_status;
    logic      push;
    logic      pop;

    upd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    upd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    upd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

// ===== verif/url_percent_decoder_checker.sv =====
// ============================================================================
// url_percent_decoder_checker
// Watches both channels of the URL percent decoder and predicts the decoded
// byte stream from each accepted input transfer. It compares every output
// transfer field by field against the oldest predicted byte and hands the
// mismatch count and the number of outstanding bytes to the testbench top.
// ============================================================================
module url_percent_decoder_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    upd_in_if    i_in,
    upd_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_decoded;

    // Predicted escape state, kept apart from the block's own.
    t_phase     esc_phase;
    logic [7:0] first_digit;

    t_decoded decoded_fifo[$];
    int       mismatch_count = 0;
    int       outstanding = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = outstanding;

    function automatic logic is_hex_char(input logic [7:0] b);
        return (b inside {[C_DIG_0:C_DIG_9]}) || (b inside {[C_UP_A:C_UP_F]}) ||
               (b inside {[C_LO_A:C_LO_F]});
    endfunction

    // Setting bit 5 folds upper-case letters onto lower case.
    function automatic logic [3:0] nibble_of(input logic [7:0] b);
        logic [7:0] folded;
        if (b inside {[C_DIG_0:C_DIG_9]}) begin
            return 4'(b - C_DIG_0);
        end
        folded = b | 8'h20;
        return 4'(folded - C_LO_A + 8'd10);
    endfunction

    task automatic report_mismatch(input string what, input t_decoded want,
                                   input t_decoded got);
        $display("[%0t] mismatch (%s): expected byte %02h last %0b, got byte %02h last %0b",
                 $realtime, what, want.data, want.last, got.data, got.last);
        mismatch_count++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        decoded_fifo.push_back('{data: b, last: 1'b0});
    endtask

    // A byte seen with no escape pending.
    task automatic decode_plain(input logic [7:0] b, input logic last);
        if (b == C_PLUS) begin
            push_byte(C_SPACE);
        end else if (b == C_PERCENT && !last) begin
            esc_phase = PH_PCT;
        end else begin
            push_byte(b);
        end
    endtask

    // Predict the decoded bytes caused by one input transfer.
    task automatic decode_char(input logic [7:0] b, input logic last);
        t_phase was;
        int     base;
        was  = esc_phase;
        base = decoded_fifo.size();
        esc_phase = PH_IDLE;
        case (was)
            PH_PCT: begin
                if (is_hex_char(b) && !last) begin
                    esc_phase   = PH_DIGIT;
                    first_digit = b;
                end else begin
                    push_byte(C_PERCENT);
                    decode_plain(b, last);
                end
            end
            PH_DIGIT: begin
                if (is_hex_char(b)) begin
                    push_byte({nibble_of(first_digit), nibble_of(b)});
                end else begin
                    push_byte(C_PERCENT);
                    push_byte(first_digit);
                    decode_plain(b, last);
                end
            end
            default: begin
                decode_plain(b, last);
            end
        endcase

        // The final character of a string clears everything and marks its last byte.
        if (last) begin
            esc_phase   = PH_IDLE;
            first_digit = 8'h00;
            if (decoded_fifo.size() > base) begin
                decoded_fifo[decoded_fifo.size()-1].last = 1'b1;
            end
        end else if (esc_phase != PH_DIGIT) begin
            first_digit = 8'h00;
        end
    endtask

    // Predict on input transfers, compare on output transfers.
    always @(posedge i_clk) begin
        t_decoded got;
        t_decoded want;
        if (!i_rst_n) begin
            esc_phase   = PH_IDLE;
            first_digit = 8'h00;
            decoded_fifo.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                decode_char(i_in.in_byte, i_in.in_last);
            end
            if (i_out.valid && i_out.ready) begin
                got = '{data: i_out.out_byte, last: i_out.out_last};
                if (decoded_fifo.size() == 0) begin
                    report_mismatch("no byte expected", '0, got);
                end else begin
                    want = decoded_fifo.pop_front();
                    if (got.data !== want.data || got.last !== want.last) begin
                        report_mismatch("wrong field", want, got);
                    end
                end
            end
        end
        outstanding = decoded_fifo.size();
    end

endmodule

// ===== verif/url_percent_decoder_unit_tb.sv =====
// ============================================================================
// url_percent_decoder_unit_tb
// Drives encoded strings into the URL percent decoder under several idle and
// stall mixes: a directed set of escapes and broken escapes, a back-pressure
// stretch, then random strings mixing escapes, pluses and raw bytes. A
// checker beside the block predicts and compares; this top gives the verdict.
// ============================================================================
module url_percent_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    localparam int HOLD_LEN       = 150;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int ITEMS_PER_MIX  = 60;

    logic i_clk;
    logic i_rst_n;

    upd_in_if  in_ch ();
    upd_out_if out_ch ();

    int fail_count;
    int pending_count;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int holds_requested = 0;
    int items_sent      = 0;
    int quiet_cycles    = 0;

    url_percent_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    url_percent_decoder_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, plus long hold-offs counted here on request.
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != holds_requested) begin
                holds_served = holds_requested;
                hold_left    = HOLD_LEN;
            end
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // One input transfer, preceded by random idle cycles with noise on the payload.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid   = 1'b0;
            in_ch.in_byte = 8'($urandom_range(255));
            in_ch.in_last = 1'($urandom_range(1));
            @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.in_byte = b;
        in_ch.in_last = last;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10) begin
            return 8'(C_DIG_0 + v);
        end
        return 8'(($urandom_range(1) ? C_UP_A : C_LO_A) + v - 10);
    endfunction

    // A string of valid escapes, pluses, broken escapes and raw bytes.
    task automatic send_random_string();
        logic [7:0] text[$];
        int         pieces;
        int         kind;
        pieces = $urandom_range(1, 10);
        repeat (pieces) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                text.push_back(C_PERCENT);
                text.push_back(rand_hex_char());
                text.push_back(rand_hex_char());
            end else if (kind < 45) begin
                text.push_back(C_PLUS);
            end else if (kind < 52) begin
                text.push_back(C_PERCENT);
            end else if (kind < 60) begin
                text.push_back(C_PERCENT);
                text.push_back(rand_hex_char());
            end else begin
                text.push_back(8'($urandom_range(255)));
            end
        end
        foreach (text[i]) begin
            send_byte(text[i], i == text.size() - 1);
        end
    endtask

    task automatic wait_drained();
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int mix_end;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        i_rst_n       = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: byte extremes, plus, both digit cases and every broken escape.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(C_PLUS, 1'b1);
        send_text("%00%Ff");
        send_text("%G");
        send_text("%4%41");
        send_text("%4x");
        send_text("%%");
        send_text("%");
        send_text("%A");
        send_text("%4F");

        // Long receiver hold-off while the sender keeps offering, then a full pause.
        holds_requested++;
        mix_end = items_sent + 30;
        while (items_sent < mix_end) begin
            send_random_string();
        end
        wait_drained();

        // Random strings under each idle and stall mix.
        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            mix_end = items_sent + ITEMS_PER_MIX;
            while (items_sent < mix_end) begin
                send_random_string();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
